// ----- hdl/pbcu_pkg.sv -----
// blend mode codes and lane constants shared by the pixel blend and composite unit
package pbcu_pkg;

	localparam int MODE_W = 5;
	localparam int NUM_LANES = 4;
	localparam int ALPHA_LANE = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_MIX           = 5'd0,
		MODE_PLUS          = 5'd1,
		MODE_MINUS         = 5'd2,
		MODE_DIFF          = 5'd3,
		MODE_BURN          = 5'd4,
		MODE_DODGE         = 5'd5,
		MODE_SCREEN        = 5'd6,
		MODE_OVERLAY       = 5'd7,
		MODE_OVER          = 5'd8,
		MODE_DISJOINT_OVER = 5'd9,
		MODE_IN            = 5'd10,
		MODE_MASK          = 5'd11,
		MODE_MATTE         = 5'd12,
		MODE_OUT           = 5'd13,
		MODE_PREMULT       = 5'd14,
		MODE_UNPREMULT     = 5'd15,
		MODE_INSIDE        = 5'd16,
		MODE_OUTSIDE       = 5'd17
	} mode_t;

endpackage

// ----- hdl/pixel_blend_composite_unit.sv -----
// pixel blend and composite unit: blend modes, alpha compositing and final mix
//
// Usage: each request on the input channel (in_valid / in_stall) carries one
// foreground and one background RGBA pixel plus mix and mask amounts, signed
// fixed point with FRAC_BITS fraction bits. One composited pixel leaves per
// request on the output channel (out_valid / out_stall) with a saturated flag.
// The blend mode is written through cfg_valid / cfg_ready / blend_mode while
// the unit is idle; cfg_ready is always high.
// Throughput: one pixel per clock while out_stall does not hold the pipeline.
// QW = max(COMP_BITS, FRAC_BITS+1) + 2 + FRAC_BITS is the depth of the
// bit-per-stage restoring divider used by burn, dodge, disjoint-over and
// unpremultiply.
// Reset clears all valid bits and sets the mode to mix.
// When out_stall is high while a result is shown, the whole pipeline holds
// and in_stall rises; bubbles in the pipeline are not squeezed out.
module pixel_blend_composite_unit
	import pbcu_pkg::*;
#(
	parameter int FRAC_BITS = 12,
	parameter int COMP_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [MODE_W-1:0]           blend_mode,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [COMP_BITS-1:0] fg_red,
	input  logic signed [COMP_BITS-1:0] fg_green,
	input  logic signed [COMP_BITS-1:0] fg_blue,
	input  logic signed [COMP_BITS-1:0] fg_alpha,
	input  logic signed [COMP_BITS-1:0] bg_red,
	input  logic signed [COMP_BITS-1:0] bg_green,
	input  logic signed [COMP_BITS-1:0] bg_blue,
	input  logic signed [COMP_BITS-1:0] bg_alpha,
	input  logic signed [COMP_BITS-1:0] mix_amount,
	input  logic signed [COMP_BITS-1:0] mask_amount,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [COMP_BITS-1:0] out_red,
	output logic signed [COMP_BITS-1:0] out_green,
	output logic signed [COMP_BITS-1:0] out_blue,
	output logic signed [COMP_BITS-1:0] out_alpha,
	output logic                        saturated
);

	localparam int C = COMP_BITS;
	localparam int F = FRAC_BITS;
	// working width of sums and differences of components and one
	localparam int W = ((C > F + 1) ? C : F + 1) + 2;
	// quotient bits and guard exponent
	localparam int QW = W + F;
	localparam int GB = 61 - C;
	localparam int XW = (QW < GB + 1) ? QW : GB + 1;
	localparam bit QCLAMP = (QW > GB);
	// first multiplier operand, products and per-lane result widths
	localparam int AW = (W > XW + 1) ? W : XW + 1;
	localparam int PW1 = AW + W;
	localparam int PW2 = 2 * W;
	localparam int RW = ((PW1 - F > W) ? PW1 - F : W) + 3;
	localparam bit GCLAMP = (RW > GB + 1);
	localparam int VW = (RW < GB + 2) ? RW : GB + 2;
	// final mix split into two partial products
	localparam int LO = VW / 2;
	localparam int HW = VW - LO;
	localparam int PL = LO + 1 + C;
	localparam int PH = HW + C;
	localparam int PB = C + W;
	localparam int PV = VW + C;
	localparam int SM = (PV - F > PB - F) ? PV - F : PB - F;
	localparam int SW = ((SM > VW) ? SM : VW) + 2;

	localparam logic signed [W-1:0] ONE_W = (W)'(1) << F;
	localparam logic signed [W-1:0] HALF_W = ONE_W >>> 1;
	localparam bit NZ1 = (64'd10000000 < (64'd1 << F));
	localparam logic signed [PW1-1:0] H1 = (PW1)'(1) << (F - 1);
	localparam logic signed [PW2-1:0] H2 = (PW2)'(1) << (F - 1);
	localparam logic signed [PV-1:0] HV = (PV)'(1) << (F - 1);
	localparam logic signed [PB-1:0] HB = (PB)'(1) << (F - 1);
	localparam logic signed [RW-1:0] GUARD_R = (RW)'(1) << GB;
	localparam logic [QW-1:0] GUARD_Q = (QW)'(1) << GB;
	localparam logic signed [SW-1:0] CMAX_S = (SW)'({1'b0, {(C - 1){1'b1}}});
	localparam logic signed [SW-1:0] CMIN_S = ~CMAX_S;

	typedef struct packed {
		mode_t                            mode;
		logic [NUM_LANES-1:0][C-1:0]      fg;
		logic [NUM_LANES-1:0][C-1:0]      bg;
		logic [C-1:0]                     mix;
		logic [C-1:0]                     msk;
	} pix_t;

	typedef struct packed {
		logic [QW:0]   dd;
		logic [W-1:0]  dv;
		logic [W-1:0]  rem;
		logic [QW-1:0] quo;
		logic          neg;
		logic          en;
	} dlane_t;

	function automatic logic signed [W-1:0] wx(input logic [C-1:0] v);
		return (W)'($signed(v));
	endfunction

	// magnitude below 1e-7
	function automatic logic nz(input logic signed [W-1:0] x);
		return (x == '0) || (NZ1 && ((x == (W)'(1)) || (x == '1)));
	endfunction

	mode_t mode_q;
	logic  adv;

	logic  vld_s1;
	pix_t  pix_s1;
	logic  vld_sd [QW+1];
	pix_t  pix_sd [QW+1];
	dlane_t [NUM_LANES-1:0] dl_sd [QW+1];
	dlane_t [NUM_LANES-1:0] dl_st;
	dlane_t [NUM_LANES-1:0] dl_nx [1:QW];

	logic                vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	pix_t                pix_s3, pix_s4, pix_s5;
	logic signed [XW:0]  x_s3 [NUM_LANES];
	logic signed [XW:0]  x_s4 [NUM_LANES];
	logic                flag_s3, flag_s4, flag_s5, flag_s6, sat_s7;
	logic signed [PW1-1:0] p1_s4 [NUM_LANES];
	logic signed [PW2-1:0] p2_s4 [NUM_LANES];
	logic signed [VW-1:0]  v_s5 [NUM_LANES];
	logic signed [VW-1:0]  v_s6 [NUM_LANES];
	logic                  blend_s5, blend_s6;
	logic signed [PL-1:0]  pl_s6 [NUM_LANES];
	logic signed [PH-1:0]  ph_s6 [NUM_LANES];
	logic signed [PB-1:0]  pb_s6 [NUM_LANES];
	logic signed [C-1:0]   res_s7 [NUM_LANES];

	logic signed [XW:0]    x_c [NUM_LANES];
	logic                  flag_c3;
	logic signed [PW1-1:0] p1_c [NUM_LANES];
	logic signed [PW2-1:0] p2_c [NUM_LANES];
	logic signed [VW-1:0]  v_c [NUM_LANES];
	logic                  flag_c5, blend_c5;
	logic signed [PL-1:0]  pl_c [NUM_LANES];
	logic signed [PH-1:0]  ph_c [NUM_LANES];
	logic signed [PB-1:0]  pb_c [NUM_LANES];
	logic signed [C-1:0]   res_c [NUM_LANES];
	logic                  flag_c7;

	// mode register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MIX;
		end else if (cfg_valid) begin
			mode_q <= mode_t'(blend_mode);
		end
	end

	// whole pipeline moves unless a shown result is stalled
	assign adv = !(vld_s7 && out_stall);
	assign in_stall = !adv;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int j = 0; j <= QW; j++) begin
				vld_sd[j] <= 1'b0;
			end
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_sd[0] <= vld_s1;
			for (int j = 1; j <= QW; j++) begin
				vld_sd[j] <= vld_sd[j-1];
			end
			vld_s3 <= vld_sd[QW];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// divider setup: operands and rounding offset per lane
	always_comb begin
		logic signed [W-1:0] f, b, fa, ba, n, d;
		logic [W-1:0] mn, md;
		logic en;
		for (int i = 0; i < NUM_LANES; i++) begin
			f = wx(pix_s1.fg[i]);
			b = wx(pix_s1.bg[i]);
			fa = wx(pix_s1.fg[ALPHA_LANE]);
			ba = wx(pix_s1.bg[ALPHA_LANE]);
			n = '0;
			d = (W)'(1);
			en = 1'b0;
			case (pix_s1.mode)
				MODE_BURN: begin
					n = ONE_W - b;
					d = f;
					en = !nz(f);
				end
				MODE_DODGE: begin
					n = b;
					d = ONE_W - f;
					en = !nz(ONE_W - f);
				end
				MODE_DISJOINT_OVER: begin
					n = ONE_W - fa;
					d = ba;
					en = (i != ALPHA_LANE) && ((fa + ba) > ONE_W) && !nz(ba);
				end
				MODE_UNPREMULT: begin
					n = f;
					d = fa;
					en = (i != ALPHA_LANE) && (fa > 0);
				end
				default: begin
				end
			endcase
			if (!en) begin
				n = '0;
				d = (W)'(1);
			end
			mn = n[W-1] ? -n : n;
			md = d[W-1] ? -d : d;
			dl_st[i].dd = ({1'b0, mn, {F{1'b0}}} << 1) + (QW + 1)'(md);
			dl_st[i].dv = md << 1;
			dl_st[i].rem = (W)'(dl_st[i].dd[QW]);
			dl_st[i].quo = '0;
			dl_st[i].neg = n[W-1] ^ d[W-1];
			dl_st[i].en = en;
		end
	end

	// restoring divider, one quotient bit per stage
	always_comb begin
		logic [W:0] t;
		for (int j = 1; j <= QW; j++) begin
			dl_nx[j] = dl_sd[j-1];
			for (int i = 0; i < NUM_LANES; i++) begin
				t = {dl_sd[j-1][i].rem, dl_sd[j-1][i].dd[QW-j]};
				if (t >= {1'b0, dl_sd[j-1][i].dv}) begin
					dl_nx[j][i].rem = (W)'(t - {1'b0, dl_sd[j-1][i].dv});
					dl_nx[j][i].quo[QW-j] = 1'b1;
				end else begin
					dl_nx[j][i].rem = t[W-1:0];
				end
			end
		end
	end

	// input and divider stage registers
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1.mode <= mode_q;
			pix_s1.fg[0] <= fg_red;
			pix_s1.fg[1] <= fg_green;
			pix_s1.fg[2] <= fg_blue;
			pix_s1.fg[3] <= fg_alpha;
			pix_s1.bg[0] <= bg_red;
			pix_s1.bg[1] <= bg_green;
			pix_s1.bg[2] <= bg_blue;
			pix_s1.bg[3] <= bg_alpha;
			pix_s1.mix <= mix_amount;
			pix_s1.msk <= mask_amount;
			pix_sd[0] <= pix_s1;
			for (int j = 1; j <= QW; j++) begin
				pix_sd[j] <= pix_sd[j-1];
			end
			dl_sd[0] <= dl_st;
			for (int j = 1; j <= QW; j++) begin
				dl_sd[j] <= dl_nx[j];
			end
		end
	end

	// quotient guard clamp and sign
	always_comb begin
		logic [QW-1:0] qm;
		logic [XW-1:0] xm;
		logic qc;
		flag_c3 = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			qm = dl_sd[QW][i].quo;
			qc = QCLAMP && (qm > GUARD_Q);
			xm = qc ? (XW)'(GUARD_Q) : qm[XW-1:0];
			if (!dl_sd[QW][i].en) begin
				x_c[i] = '0;
			end else if (dl_sd[QW][i].neg) begin
				x_c[i] = -$signed({1'b0, xm});
			end else begin
				x_c[i] = $signed({1'b0, xm});
			end
			flag_c3 = flag_c3 | (dl_sd[QW][i].en & qc);
		end
	end

	// multiplier operand select and products
	always_comb begin
		logic signed [W-1:0] f, b, fa, ba, mix, msk;
		logic signed [AW-1:0] a1;
		logic signed [W-1:0] b1;
		for (int i = 0; i < NUM_LANES; i++) begin
			f = wx(pix_s3.fg[i]);
			b = wx(pix_s3.bg[i]);
			fa = wx(pix_s3.fg[ALPHA_LANE]);
			ba = wx(pix_s3.bg[ALPHA_LANE]);
			mix = wx(pix_s3.mix);
			msk = wx(pix_s3.msk);
			a1 = '0;
			b1 = '0;
			case (pix_s3.mode)
				MODE_MIX: begin
					a1 = (AW)'(f - b);
					b1 = mix;
				end
				MODE_SCREEN: begin
					a1 = (AW)'(ONE_W - f);
					b1 = ONE_W - b;
				end
				MODE_OVERLAY: begin
					if (b < HALF_W) begin
						a1 = (AW)'(f);
						b1 = b;
					end else begin
						a1 = (AW)'(ONE_W - f);
						b1 = ONE_W - b;
					end
				end
				MODE_OVER: begin
					a1 = (i == ALPHA_LANE) ? (AW)'(ba) : (AW)'(b);
					b1 = ONE_W - fa;
				end
				MODE_DISJOINT_OVER: begin
					a1 = (AW)'(x_s3[i]);
					b1 = b;
				end
				MODE_IN: begin
					a1 = (AW)'(f);
					b1 = ba;
				end
				MODE_MASK: begin
					a1 = (AW)'(b);
					b1 = fa;
				end
				MODE_MATTE, MODE_PREMULT: begin
					a1 = (AW)'(f);
					b1 = fa;
				end
				MODE_OUT: begin
					a1 = (AW)'(f);
					b1 = ONE_W - ba;
				end
				MODE_INSIDE: begin
					a1 = (AW)'(f);
					b1 = msk;
				end
				MODE_OUTSIDE: begin
					a1 = (AW)'(f);
					b1 = ONE_W - msk;
				end
				default: begin
				end
			endcase
			p1_c[i] = a1 * b1;
			p2_c[i] = b * (ONE_W - fa);
		end
	end

	// per-channel result and guard clamp
	always_comb begin
		logic signed [RW-1:0] f, b, fa, ba, x, one, sum, rnd1, rnd2, r;
		logic signed [PW1-1:0] r1s;
		logic signed [PW2-1:0] r2s;
		logic lane_a;
		flag_c5 = flag_s4;
		blend_c5 = (pix_s4.mode inside {[MODE_PLUS:MODE_OUT]});
		for (int i = 0; i < NUM_LANES; i++) begin
			f = (RW)'(wx(pix_s4.fg[i]));
			b = (RW)'(wx(pix_s4.bg[i]));
			fa = (RW)'(wx(pix_s4.fg[ALPHA_LANE]));
			ba = (RW)'(wx(pix_s4.bg[ALPHA_LANE]));
			x = (RW)'(x_s4[i]);
			one = (RW)'(ONE_W);
			sum = fa + ba;
			lane_a = (i == ALPHA_LANE);
			r1s = p1_s4[i] + (p1_s4[i][PW1-1] ? H1 - 1 : H1);
			r2s = p2_s4[i] + (p2_s4[i][PW2-1] ? H2 - 1 : H2);
			rnd1 = (RW)'($signed(r1s[PW1-1:F]));
			rnd2 = (RW)'($signed(r2s[PW2-1:F]));
			case (pix_s4.mode)
				MODE_MIX:      r = b + rnd1;
				MODE_PLUS:     r = f + b;
				MODE_MINUS:    r = b - f;
				MODE_DIFF:     r = (f > b) ? f - b : b - f;
				MODE_BURN:     r = nz(wx(pix_s4.fg[i])) ? '0 : one - x;
				MODE_DODGE:    r = nz(ONE_W - wx(pix_s4.fg[i])) ? one : x;
				MODE_SCREEN:   r = one - rnd1;
				MODE_OVERLAY: begin
					if (wx(pix_s4.bg[i]) < HALF_W) begin
						r = rnd1 <<< 1;
					end else begin
						r = one - (rnd1 <<< 1);
					end
				end
				MODE_OVER:     r = (lane_a ? fa : f) + rnd1;
				MODE_DISJOINT_OVER: begin
					if (lane_a) begin
						r = (sum < one) ? sum : one;
					end else if (sum <= one) begin
						r = f + b;
					end else begin
						r = f + rnd1;
					end
				end
				MODE_IN, MODE_MASK, MODE_OUT, MODE_INSIDE, MODE_OUTSIDE: r = rnd1;
				MODE_MATTE:    r = (lane_a ? fa : rnd1) + rnd2;
				MODE_PREMULT:  r = lane_a ? fa : rnd1;
				MODE_UNPREMULT: r = lane_a ? fa : x;
				default:       r = '0;
			endcase
			if (GCLAMP && (r > GUARD_R)) begin
				r = GUARD_R;
				flag_c5 = 1'b1;
			end else if (GCLAMP && (r < -GUARD_R)) begin
				r = -GUARD_R;
				flag_c5 = 1'b1;
			end
			v_c[i] = (VW)'(r);
		end
	end

	// final mix partial products
	always_comb begin
		logic signed [W-1:0] mix;
		mix = wx(pix_s5.mix);
		for (int i = 0; i < NUM_LANES; i++) begin
			pl_c[i] = $signed({1'b0, v_s5[i][LO-1:0]}) * $signed(pix_s5.mix);
			ph_c[i] = $signed(v_s5[i][VW-1:LO]) * $signed(pix_s5.mix);
			pb_c[i] = $signed(pix_s5.bg[i]) * (ONE_W - mix);
		end
	end

	// final mix sum, rounding and output saturation
	always_comb begin
		logic signed [PV-1:0] pv, rv;
		logic signed [PB-1:0] rb;
		logic signed [SW-1:0] s;
		flag_c7 = flag_s6;
		for (int i = 0; i < NUM_LANES; i++) begin
			pv = ((PV)'(ph_s6[i]) <<< LO) + (PV)'(pl_s6[i]);
			rv = pv + (pv[PV-1] ? HV - 1 : HV);
			rb = pb_s6[i] + (pb_s6[i][PB-1] ? HB - 1 : HB);
			if (blend_s6) begin
				s = (SW)'($signed(rv[PV-1:F])) + (SW)'($signed(rb[PB-1:F]));
			end else begin
				s = (SW)'(v_s6[i]);
			end
			if (s > CMAX_S) begin
				s = CMAX_S;
				flag_c7 = 1'b1;
			end else if (s < CMIN_S) begin
				s = CMIN_S;
				flag_c7 = 1'b1;
			end
			res_c[i] = s[C-1:0];
		end
	end

	// post-divider stage registers
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s3 <= pix_sd[QW];
			flag_s3 <= flag_c3;
			pix_s4 <= pix_s3;
			flag_s4 <= flag_s3;
			pix_s5 <= pix_s4;
			flag_s5 <= flag_c5;
			blend_s5 <= blend_c5;
			flag_s6 <= flag_s5;
			blend_s6 <= blend_s5;
			sat_s7 <= flag_c7;
			for (int i = 0; i < NUM_LANES; i++) begin
				x_s3[i] <= x_c[i];
				x_s4[i] <= x_s3[i];
				p1_s4[i] <= p1_c[i];
				p2_s4[i] <= p2_c[i];
				v_s5[i] <= v_c[i];
				v_s6[i] <= v_s5[i];
				pl_s6[i] <= pl_c[i];
				ph_s6[i] <= ph_c[i];
				pb_s6[i] <= pb_c[i];
				res_s7[i] <= res_c[i];
			end
		end
	end

	assign out_valid = vld_s7;
	assign out_red = res_s7[0];
	assign out_green = res_s7[1];
	assign out_blue = res_s7[2];
	assign out_alpha = res_s7[3];
	assign saturated = sat_s7;

endmodule

// ----- tb/pixel_blend_composite_unit_tb.sv -----
// self-checking testbench for the pixel blend and composite unit
module pixel_blend_composite_unit_tb;
	import pbcu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 12;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam longint GUARD_LIM = 64'sd1 << (61 - 16);
	localparam int LATENCY = 44;
	localparam logic [MODE_W-1:0] MODE_UNDEF_LOW = 5'd18;
	localparam logic [MODE_W-1:0] MODE_UNDEF_TOP = 5'd31;

	// lane order: fg r g b a, bg r g b a, mix, mask
	typedef struct {
		logic signed [15:0] v[10];
	} pixel_req_t;

	typedef struct {
		logic signed [15:0] ch[4];
		logic sat;
	} pixel_res_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		pixel_req_t px;
		bit typed;
		pixel_res_t res;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [MODE_W-1:0] blend_mode = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] fg_red = 0, fg_green = 0, fg_blue = 0, fg_alpha = 0;
	logic signed [15:0] bg_red = 0, bg_green = 0, bg_blue = 0, bg_alpha = 0;
	logic signed [15:0] mix_amount = 0, mask_amount = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [15:0] out_red, out_green, out_blue, out_alpha;
	logic saturated;

	logic [MODE_W-1:0] cur_mode = MODE_MIX;
	pixel_res_t pending_pixels[$];
	stim_row_t directed_rows[$];
	int errs = 0;
	int pixels_sent = 0;
	bit calm = 0;
	bit hold_req = 0;

	pixel_blend_composite_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .blend_mode(blend_mode),
		.in_valid(in_valid), .in_stall(in_stall),
		.fg_red(fg_red), .fg_green(fg_green), .fg_blue(fg_blue), .fg_alpha(fg_alpha),
		.bg_red(bg_red), .bg_green(bg_green), .bg_blue(bg_blue), .bg_alpha(bg_alpha),
		.mix_amount(mix_amount), .mask_amount(mask_amount),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.out_alpha(out_alpha), .saturated(saturated)
	);

	// clock
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// fixed-point helpers
	function automatic longint mag_of(longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint p, m;
		p = a * b;
		m = (mag_of(p) + (64'sd1 << (FRAC - 1))) >>> FRAC;
		return p < 0 ? -m : m;
	endfunction

	function automatic longint guard_clamp(longint x, ref bit flag);
		if (x > GUARD_LIM) begin
			flag = 1;
			return GUARD_LIM;
		end
		if (x < -GUARD_LIM) begin
			flag = 1;
			return -GUARD_LIM;
		end
		return x;
	endfunction

	function automatic longint qdiv(longint n, longint d, ref bit flag);
		longint mn, md, q;
		mn = mag_of(n) << FRAC;
		md = mag_of(d);
		q = (2 * mn + md) / (2 * md);
		return guard_clamp(((n < 0) != (d < 0)) ? -q : q, flag);
	endfunction

	function automatic bit near_zero(longint x);
		return mag_of(x) * 10000000 < ONE;
	endfunction

	// expected composite for one pixel under a given mode
	function automatic pixel_res_t composite_pixel(logic [MODE_W-1:0] mode, pixel_req_t p);
		longint f, b, fa, ba, mx, mk, v, sum, x;
		longint r[4];
		bit flag, mixed, known;
		pixel_res_t o;
		flag = 0;
		mixed = 1;
		known = 1;
		fa = p.v[3];
		ba = p.v[7];
		mx = p.v[8];
		mk = p.v[9];
		for (int i = 0; i < 4; i++) begin
			f = p.v[i];
			b = p.v[4 + i];
			case (mode)
				MODE_MIX: r[i] = b + qmul(f - b, mx);
				MODE_PLUS: r[i] = f + b;
				MODE_MINUS: r[i] = b - f;
				MODE_DIFF: r[i] = f > b ? f - b : b - f;
				MODE_BURN: r[i] = near_zero(f) ? 0 : ONE - qdiv(ONE - b, f, flag);
				MODE_DODGE: r[i] = near_zero(ONE - f) ? ONE : qdiv(b, ONE - f, flag);
				MODE_SCREEN: r[i] = ONE - qmul(ONE - f, ONE - b);
				MODE_OVERLAY: begin
					if (b < (ONE >>> 1)) r[i] = 2 * qmul(f, b);
					else r[i] = ONE - 2 * qmul(ONE - f, ONE - b);
				end
				MODE_OVER: begin
					if (i == ALPHA_LANE) r[i] = fa + qmul(ba, ONE - fa);
					else r[i] = f + qmul(b, ONE - fa);
				end
				MODE_DISJOINT_OVER: begin
					sum = fa + ba;
					if (i == ALPHA_LANE) begin
						r[i] = sum < ONE ? sum : ONE;
					end else if (sum <= ONE) begin
						r[i] = f + b;
					end else begin
						x = near_zero(ba) ? 0 : qdiv(ONE - fa, ba, flag);
						r[i] = f + qmul(b, x);
					end
				end
				MODE_IN: r[i] = qmul(f, ba);
				MODE_MASK: r[i] = qmul(b, fa);
				MODE_MATTE: r[i] = (i == ALPHA_LANE ? fa : qmul(f, fa)) + qmul(b, ONE - fa);
				MODE_OUT: r[i] = qmul(f, ONE - ba);
				MODE_PREMULT: begin
					r[i] = i == ALPHA_LANE ? fa : qmul(f, fa);
					mixed = 0;
				end
				MODE_UNPREMULT: begin
					if (i == ALPHA_LANE) r[i] = fa;
					else r[i] = fa > 0 ? qdiv(f, fa, flag) : 0;
					mixed = 0;
				end
				MODE_INSIDE: begin
					r[i] = qmul(f, mk);
					mixed = 0;
				end
				MODE_OUTSIDE: begin
					r[i] = qmul(f, ONE - mk);
					mixed = 0;
				end
				default: begin
					r[i] = 0;
					known = 0;
				end
			endcase
		end
		// final mix against background and saturation
		for (int i = 0; i < 4; i++) begin
			v = guard_clamp(r[i], flag);
			if (known && mixed && mode != MODE_MIX)
				v = qmul(v, mx) + qmul(longint'(p.v[4 + i]), ONE - mx);
			if (v > 32767) begin
				v = 32767;
				flag = 1;
			end
			if (v < -32768) begin
				v = -32768;
				flag = 1;
			end
			o.ch[i] = v[15:0];
		end
		o.sat = flag;
		return o;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		case ($urandom % 4)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 12288) - 4096);
			2: case ($urandom % 6)
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				3: return 16'sd4096;
				4: return -16'sd4096;
				default: return 16'sd2048;
			endcase
			default: return 16'($urandom_range(0, 8) - 4);
		endcase
	endfunction

	function automatic pixel_req_t rand_pixel();
		pixel_req_t p;
		for (int i = 0; i < 10; i++)
			p.v[i] = rand_comp();
		// keep the mix mostly in the useful range
		if ($urandom % 4 != 0)
			p.v[8] = 16'($urandom_range(0, 4096));
		return p;
	endfunction

	function automatic pixel_res_t flat_res(int c, bit sat);
		pixel_res_t o;
		for (int i = 0; i < 4; i++)
			o.ch[i] = 16'(c);
		o.sat = sat;
		return o;
	endfunction

	task automatic add_row(logic [MODE_W-1:0] mode, int f, int fa, int b, int ba,
			int mx, int mk, bit typed, int ev, bit esat);
		stim_row_t row;
		row.mode = mode;
		for (int i = 0; i < 3; i++) begin
			row.px.v[i] = 16'(f);
			row.px.v[4 + i] = 16'(b);
		end
		row.px.v[3] = 16'(fa);
		row.px.v[7] = 16'(ba);
		row.px.v[8] = 16'(mx);
		row.px.v[9] = 16'(mk);
		row.typed = typed;
		row.res = flat_res(ev, esat);
		directed_rows.push_back(row);
	endtask

	// mode write once the pipeline has drained
	task automatic write_mode(logic [MODE_W-1:0] m);
		in_valid <= 0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		cfg_valid <= 1;
		blend_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		cur_mode = m;
	endtask

	// send one request, idling at random first
	task automatic send_pixel(pixel_req_t p, bit typed, pixel_res_t res);
		if (!calm && $urandom_range(0, 99) < 29) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		fg_red <= p.v[0];
		fg_green <= p.v[1];
		fg_blue <= p.v[2];
		fg_alpha <= p.v[3];
		bg_red <= p.v[4];
		bg_green <= p.v[5];
		bg_blue <= p.v[6];
		bg_alpha <= p.v[7];
		mix_amount <= p.v[8];
		mask_amount <= p.v[9];
		do @(posedge clk); while (in_stall);
		pending_pixels.push_back(typed ? res : composite_pixel(cur_mode, p));
		pixels_sent++;
		calm = pixels_sent >= 300 && pixels_sent < 380;
		if (pixels_sent == 150)
			hold_req = 1;
	endtask

	// output side: random stalls, one long hold-off, and checking
	initial begin
		int hold_cnt;
		pixel_res_t e;
		logic signed [15:0] got[4];
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{out_red, out_green, out_blue, out_alpha};
				if (pending_pixels.size() == 0) begin
					errs++;
					$display("%0t: result with no request pending, actual %0d %0d %0d %0d",
						$time, got[0], got[1], got[2], got[3]);
				end else begin
					e = pending_pixels.pop_front();
					for (int i = 0; i < 4; i++)
						if (got[i] !== e.ch[i]) begin
							errs++;
							$display("%0t: lane %0d expected %0d actual %0d",
								$time, i, e.ch[i], got[i]);
						end
					if (saturated !== e.sat) begin
						errs++;
						$display("%0t: saturated expected %0b actual %0b",
							$time, e.sat, saturated);
					end
				end
			end
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 120;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1;
			end else begin
				out_stall <= !calm && $urandom_range(0, 99) < 29;
			end
		end
	end

	// stimulus
	initial begin
		pixel_res_t none;
		logic [MODE_W-1:0] m;
		none = flat_res(0, 0);
		// directed table: extremes, every mode, special cases
		add_row(MODE_MIX, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		add_row(MODE_MIX, 100, 100, 0, 0, 4096, 0, 1, 100, 0);
		add_row(MODE_MIX, 32767, 32767, -32768, -32768, 0, 0, 1, -32768, 0);
		add_row(MODE_PLUS, 32767, 32767, 32767, 32767, 4096, 0, 1, 32767, 1);
		add_row(MODE_MINUS, 32767, 32767, -32768, -32768, 4096, 0, 1, -32768, 1);
		add_row(MODE_DIFF, -32768, 4096, 32767, 2000, 2048, 0, 0, 0, 0);
		add_row(MODE_BURN, 0, 0, 1000, 3000, 4096, 0, 0, 0, 0);
		add_row(MODE_BURN, 1, 2000, -32768, 4096, 3000, 0, 0, 0, 0);
		add_row(MODE_DODGE, 4096, 4096, 2000, 1000, 4096, 0, 0, 0, 0);
		add_row(MODE_DODGE, 3000, 4095, 32767, 2000, 1500, 0, 0, 0, 0);
		add_row(MODE_SCREEN, 2000, 4096, 3000, 4096, 2048, 0, 0, 0, 0);
		add_row(MODE_OVERLAY, 3000, 4096, 1000, 1000, 4096, 0, 0, 0, 0);
		add_row(MODE_OVERLAY, 3000, 4096, 2048, 2048, 4096, 0, 0, 0, 0);
		add_row(MODE_OVER, 1500, 2048, 3000, 4096, 3500, 0, 0, 0, 0);
		add_row(MODE_DISJOINT_OVER, 1000, 1000, 2000, 2000, 4096, 0, 0, 0, 0);
		add_row(MODE_DISJOINT_OVER, 1000, 8000, 2000, 0, 4096, 0, 0, 0, 0);
		add_row(MODE_DISJOINT_OVER, 1000, 3000, 2000, 2000, 2000, 0, 0, 0, 0);
		add_row(MODE_IN, 3000, 4096, 1000, 2048, 4096, 0, 0, 0, 0);
		add_row(MODE_MASK, 3000, 2048, 1000, 4096, 4096, 0, 0, 0, 0);
		add_row(MODE_MATTE, 3000, 1024, 1000, 4096, -32768, 0, 0, 0, 0);
		add_row(MODE_OUT, 3000, 4096, 1000, 1024, 32767, 0, 0, 0, 0);
		add_row(MODE_PREMULT, -32768, 32767, 0, 0, 0, 0, 0, 0, 0);
		add_row(MODE_UNPREMULT, 3000, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(MODE_UNPREMULT, 32767, 1, 0, 0, 0, 0, 0, 0, 0);
		add_row(MODE_INSIDE, 3000, 4096, 0, 0, 0, 2048, 0, 0, 0);
		add_row(MODE_OUTSIDE, 3000, 4096, 0, 0, 0, -32768, 0, 0, 0);
		add_row(MODE_UNDEF_TOP, 32767, 32767, 32767, 32767, 4096, 32767, 1, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].mode != cur_mode)
				write_mode(directed_rows[k].mode);
			send_pixel(directed_rows[k].px, directed_rows[k].typed, directed_rows[k].res);
		end

		// random phases: each mode once in turn, then random picks
		for (int ph = 0; pixels_sent < 550; ph++) begin
			if (ph < 18) m = MODE_W'(ph);
			else if (ph == 18) m = MODE_UNDEF_LOW;
			else if ($urandom % 8 == 0)
				m = MODE_W'($urandom_range(MODE_UNDEF_LOW, MODE_UNDEF_TOP));
			else m = MODE_W'($urandom_range(MODE_MIX, MODE_OUTSIDE));
			write_mode(m);
			repeat ($urandom_range(10, 30))
				send_pixel(rand_pixel(), 0, none);
		end
		in_valid <= 0;

		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (errs == 0)
			$display("pixel_blend_composite_unit_tb: clean");
		else
			$display("pixel_blend_composite_unit_tb: errors");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("pixel_blend_composite_unit_tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/pbcu_pkg.sv
hdl/pixel_blend_composite_unit.sv
tb/pixel_blend_composite_unit_tb.sv
